### rtl/core/glt_pkg.sv
// glt_pkg: shared types and constants for the glyph lookup text layout block
// no dependencies; used by the interfaces, controller, datapath and top level
package glt_pkg;

    localparam int GLYPHS_DEF = 256;
    localparam int CFG_W      = 16;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_START = 2'd1,
        MODE_CHAR  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        CFG_LOWEST  = 2'd0,
        CFG_HIGHEST = 2'd1,
        CFG_COUNT   = 2'd2,
        CFG_SCALE   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        t_mode              mode;
        logic [7:0]         slot;
        logic [15:0]        code;
        logic [7:0]         advance;
        logic [7:0]         box_width;
        logic [7:0]         box_height;
        logic [5:0]         row_bytes;
        logic signed [7:0]  x_offset;
        logic signed [7:0]  y_offset;
        logic [19:0]        bmp_addr;
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
    } t_req;

    typedef struct packed {
        logic               found;
        logic               draw;
        logic signed [31:0] glyph_x;
        logic signed [31:0] glyph_y;
        logic [7:0]         out_width;
        logic [7:0]         out_height;
        logic [5:0]         out_row_bytes;
        logic [19:0]        out_bmp_addr;
        logic [23:0]        string_width;
    } t_res;

    // one table entry: encoding, metrics and bitmap location
    typedef struct packed {
        logic [15:0]        code;
        logic [7:0]         advance;
        logic [7:0]         box_width;
        logic [7:0]         box_height;
        logic [5:0]         row_bytes;
        logic signed [7:0]  x_offset;
        logic signed [7:0]  y_offset;
        logic [19:0]        bmp_addr;
    } t_glyph_rec;

    localparam int REC_W = $bits(t_glyph_rec);

    typedef struct packed {
        logic accept;   // request taken this cycle
        logic start;    // range check and first probe
        logic step;     // compare probe, narrow bounds, next probe
        logic mul;      // register the scaled offsets and advance
        logic finish;   // load result register, move pen
    } t_cmd;

    typedef struct packed {
        logic req_is_char;
        logic start_ok;
        logic eq;
        logic next_empty;
    } t_sts;

endpackage

### rtl/core/glt_req_if.sv
// glt_req_if: request channel (valid, ready, payload)
// depends on glt_pkg
interface glt_req_if;
    import glt_pkg::*;

    logic valid;
    logic ready;
    t_req data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

### rtl/core/glt_res_if.sv
// glt_res_if: result channel (valid, ready, payload)
// depends on glt_pkg
interface glt_res_if;
    import glt_pkg::*;

    logic valid;
    logic ready;
    t_res data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

### rtl/core/glt_ram.sv
// glt_ram: generic single write port ram with registered read
// no dependencies
module glt_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 256,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/core/glt_ctrl.sv
// glt_ctrl: sequencer for load, start and character requests
// depends on glt_pkg; drives the datapath through t_cmd, reads t_sts
module glt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    output logic          o_res_valid,
    input  logic          i_res_ready,
    input  glt_pkg::t_sts i_sts,
    output glt_pkg::t_cmd o_cmd
);
    import glt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SEARCH,
        S_MUL,
        S_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_res_valid, n_res_valid;
    t_cmd   cmd;

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_cmd       = cmd;

    always_comb begin
        n_state     = r_state;
        cmd         = '0;
        cmd.accept  = i_req_valid && (r_state == S_IDLE);
        n_res_valid = r_res_valid && !i_res_ready;
        unique case (r_state)
            S_IDLE: begin
                if (cmd.accept && i_sts.req_is_char) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                cmd.start = 1'b1;
                n_state   = i_sts.start_ok ? S_SEARCH : S_FINISH;
            end
            S_SEARCH: begin
                cmd.step = 1'b1;
                if (i_sts.eq) begin
                    n_state = S_MUL;
                end else if (i_sts.next_empty) begin
                    n_state = S_FINISH;
                end
            end
            S_MUL: begin
                cmd.mul = 1'b1;
                n_state = S_FINISH;
            end
            S_FINISH: begin
                // wait while the previous result still sits unclaimed
                if (!r_res_valid || i_res_ready) begin
                    cmd.finish  = 1'b1;
                    n_res_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
        end
    end
endmodule

### rtl/core/glt_datapath.sv
// glt_datapath: glyph table, search bounds, pen and width sum, result register
// depends on glt_pkg and glt_ram; controlled by glt_ctrl through t_cmd
module glt_datapath #(
    parameter int GLYPHS = glt_pkg::GLYPHS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  glt_pkg::t_cfg_idx              i_cfg_idx,
    input  logic [glt_pkg::CFG_W-1:0]      i_cfg_data,
    input  glt_pkg::t_req                  i_req,
    input  glt_pkg::t_cmd                  i_cmd,
    output glt_pkg::t_sts                  o_sts,
    output glt_pkg::t_res                  o_res
);
    import glt_pkg::*;

    localparam int IW = $clog2(GLYPHS);
    localparam int CW = $clog2(GLYPHS + 1);
    localparam int MW = (CW > 9) ? CW : 9;
    localparam int SW = (IW > 8) ? IW : 8;

    // configuration
    logic [15:0] r_lowest, r_highest;
    logic [8:0]  r_glyph_count, r_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lowest      <= '0;
            r_highest     <= '0;
            r_glyph_count <= '0;
            r_scale       <= 9'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LOWEST:  r_lowest      <= i_cfg_data[15:0];
                CFG_HIGHEST: r_highest     <= i_cfg_data[15:0];
                CFG_COUNT:   r_glyph_count <= i_cfg_data[8:0];
                CFG_SCALE:   r_scale       <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // table write on load requests
    logic [SW-1:0] slot_ext;
    logic          load_we;
    t_glyph_rec    wr_rec, rd_rec;

    assign slot_ext = SW'(i_req.slot);
    assign load_we  = i_cmd.accept && (i_req.mode == MODE_LOAD)
                      && (32'(i_req.slot) < 32'(GLYPHS));

    always_comb begin
        wr_rec.code          = i_req.code;
        wr_rec.advance       = i_req.advance;
        wr_rec.box_width     = i_req.box_width;
        wr_rec.box_height    = i_req.box_height;
        wr_rec.row_bytes     = i_req.row_bytes;
        wr_rec.x_offset      = i_req.x_offset;
        wr_rec.y_offset      = i_req.y_offset;
        wr_rec.bmp_addr      = i_req.bmp_addr;
    end

    // search bounds: [lo, hi) over the sorted entries
    logic [15:0]   r_code;
    logic [CW-1:0] r_lo, r_hi;
    logic [IW-1:0] r_mid;
    logic          r_hit;
    logic [MW-1:0] cnt_ext, cnt_lim, cnt_clamp;
    logic [CW-1:0] cnt;
    logic          range_ok, start_ok, eq, lt, next_empty, rd_en;
    logic [CW-1:0] step_lo, step_hi, base_lo, base_hi;
    logic [CW:0]   mid_sum;
    logic [IW-1:0] mid;

    assign cnt_ext   = MW'(r_glyph_count);
    assign cnt_lim   = MW'(GLYPHS);
    assign cnt_clamp = (cnt_ext > cnt_lim) ? cnt_lim : cnt_ext;
    assign cnt       = cnt_clamp[CW-1:0];

    assign range_ok  = (r_code >= r_lowest) && (r_code <= r_highest);
    assign start_ok  = range_ok && (cnt != '0);

    assign eq         = (rd_rec.code == r_code);
    assign lt         = (rd_rec.code < r_code);
    assign step_lo    = lt ? (CW'(r_mid) + CW'(1)) : r_lo;
    assign step_hi    = lt ? r_hi : CW'(r_mid);
    assign next_empty = (step_lo >= step_hi);

    assign base_lo = i_cmd.start ? '0  : step_lo;
    assign base_hi = i_cmd.start ? cnt : step_hi;
    assign mid_sum = {1'b0, base_lo} + {1'b0, base_hi} - (CW+1)'(1);
    assign mid     = mid_sum[IW:1];

    // keep the read data once the match is found
    assign rd_en = (i_cmd.start && start_ok) || (i_cmd.step && !eq && !next_empty);

    glt_ram #(
        .WIDTH(REC_W),
        .DEPTH(GLYPHS)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (load_we),
        .i_waddr(slot_ext[IW-1:0]),
        .i_wdata(wr_rec),
        .i_re   (rd_en),
        .i_raddr(mid),
        .o_rdata(rd_rec)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && (i_req.mode == MODE_CHAR)) begin
            r_code <= i_req.code;
        end
        if (i_cmd.start || i_cmd.step) begin
            r_lo  <= base_lo;
            r_hi  <= base_hi;
            r_mid <= mid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_cmd.start) begin
            r_hit <= 1'b0;
        end else if (i_cmd.step && eq) begin
            r_hit <= 1'b1;
        end
    end

    assign o_sts.req_is_char = (i_req.mode == MODE_CHAR);
    assign o_sts.start_ok    = start_ok;
    assign o_sts.eq          = eq;
    assign o_sts.next_empty  = next_empty;

    // scaled offsets and advance
    logic signed [17:0] r_px, r_py;
    logic [16:0]        r_pa;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_px <= 18'(rd_rec.x_offset) * 18'($signed({1'b0, r_scale}));
            r_py <= 18'(rd_rec.y_offset) * 18'($signed({1'b0, r_scale}));
            r_pa <= 17'(rd_rec.advance) * 17'(r_scale);
        end
    end

    // pen, width sum and result register
    logic signed [31:0] r_pen_x, r_pen_y;
    logic [23:0]        r_width_sum;
    logic [24:0]        width_add;
    logic [23:0]        width_next;
    t_res               r_res;

    assign width_add  = {1'b0, r_width_sum} + 25'(rd_rec.advance);
    assign width_next = width_add[24] ? 24'hFFFFFF : width_add[23:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_x     <= '0;
            r_pen_y     <= '0;
            r_width_sum <= '0;
        end else if (i_cmd.accept && (i_req.mode == MODE_START)) begin
            r_pen_x     <= i_req.origin_x;
            r_pen_y     <= i_req.origin_y;
            r_width_sum <= '0;
        end else if (i_cmd.finish && r_hit) begin
            r_pen_x     <= r_pen_x + $signed(32'(r_pa));
            r_width_sum <= width_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (r_hit) begin
                r_res.found             <= 1'b1;
                r_res.draw              <= (rd_rec.box_width != '0)
                                           && (rd_rec.box_height != '0);
                r_res.glyph_x           <= r_pen_x + 32'(r_px);
                r_res.glyph_y           <= r_pen_y + 32'(r_py);
                r_res.out_width         <= rd_rec.box_width;
                r_res.out_height        <= rd_rec.box_height;
                r_res.out_row_bytes     <= rd_rec.row_bytes;
                r_res.out_bmp_addr      <= rd_rec.bmp_addr;
                r_res.string_width      <= width_next;
            end else begin
                r_res.found             <= 1'b0;
                r_res.draw              <= 1'b0;
                r_res.glyph_x           <= '0;
                r_res.glyph_y           <= '0;
                r_res.out_width         <= '0;
                r_res.out_height        <= '0;
                r_res.out_row_bytes     <= '0;
                r_res.out_bmp_addr      <= '0;
                r_res.string_width      <= r_width_sum;
            end
        end
    end

    assign o_res = r_res;
endmodule

### rtl/core/glyph_lookup_text_layout_top.sv
// glyph_lookup_text_layout_top: bitmap font text layout with sorted glyph table
// depends on glt_pkg, glt_req_if, glt_res_if, glt_ctrl, glt_datapath, glt_ram
//
//   port        dir   handshake       carries
//   i_req       in    valid/ready     load, start or character request
//   o_res       out   valid/ready     one result per character request
//   i_cfg_*     in    write enable    lowest/highest code, glyph count, scale
//
// load, start and unused-mode requests are handled when taken in S_IDLE
// a character request steps through S_CHECK, S_SEARCH (k probes), S_MUL on a hit
// and S_FINISH (k <= log2(count) + 1, one table ram read per probe)
// a miss on the range check skips the search and goes straight to S_FINISH
// reset is synchronous, active low; the glyph table holds no reset value
// a finished result waits in the output register; the next request is taken
// meanwhile and only stalls at its own result if that register is still full
module glyph_lookup_text_layout_top #(
    parameter int GLYPHS = glt_pkg::GLYPHS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    glt_req_if.sink                    i_req,
    glt_res_if.source                  o_res,
    input  logic                       i_cfg_we,
    input  glt_pkg::t_cfg_idx          i_cfg_idx,
    input  logic [glt_pkg::CFG_W-1:0]  i_cfg_data
);
    import glt_pkg::*;

    t_cmd cmd;
    t_sts sts;

    glt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_req.valid),
        .o_req_ready(i_req.ready),
        .o_res_valid(o_res.valid),
        .i_res_ready(o_res.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    glt_datapath #(
        .GLYPHS(GLYPHS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_req     (i_req.data),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .o_res     (o_res.data)
    );

    // a result appears only after the finish step
    a_res_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res.valid) |-> $past(cmd.finish))
        else $error("result valid without finish step");

    // the multiply step follows a matching probe
    a_mul_after_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.mul |-> ($past(cmd.step) && $past(sts.eq)))
        else $error("multiply step without a match");

    // a miss carries no geometry and never draws
    a_miss_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.data.found) |->
            (!o_res.data.draw && o_res.data.glyph_x == '0 && o_res.data.out_width == '0))
        else $error("miss result with glyph data");

    // no new request is taken while a lookup is in flight
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.start || cmd.step || cmd.mul) |-> !i_req.ready)
        else $error("request ready during lookup");
endmodule
